// ----- hw/rtl/ungt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ungt_pkg
// Shared widths, constants and register indexes of the mu-law noise gate.
// ----------------------------------------------------------------------------
package ungt_pkg;

	localparam int CODE_W = 8;   // mu-law byte
	localparam int MAG_W  = 15;  // expanded magnitude, 0 .. 19551
	localparam int THR_W  = 15;  // gate threshold register
	localparam int SIL_W  = 16;  // max silence register
	localparam int RUN_W  = 17;  // quiet run counter, saturates at 2**SIL_W
	localparam int CFG_W  = 16;  // widest register
	localparam int CFG_IDX_W = 1;

	localparam logic [RUN_W-1:0] RUN_CAP = RUN_W'(1) << SIL_W;

	localparam logic [THR_W-1:0] GATE_THRESHOLD_RST = THR_W'(300);
	localparam logic [SIL_W-1:0] MAX_SILENCE_RST    = SIL_W'(800);

	// Expansion constants
	localparam logic [MAG_W-1:0] ULAW_BIAS = MAG_W'(33);

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GATE_THRESHOLD = 1'b0,
		REG_MAX_SILENCE    = 1'b1
	} cfg_reg_t;

endpackage

// ----- hw/rtl/ungt_expand.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ungt_expand
// Expands a mu-law byte to its linear magnitude (sign ignored).
// ----------------------------------------------------------------------------
module ungt_expand (
	input  logic [ungt_pkg::CODE_W-1:0] code,
	output logic [ungt_pkg::MAG_W-1:0]  mag
);
	import ungt_pkg::*;

	logic [CODE_W-1:0] inv;
	logic [2:0]        expo;
	logic [3:0]        mant;
	logic [MAG_W-1:0]  biased;

	// invert, split into exponent and mantissa, then ((m<<3)+33)<<e - 33
	assign inv    = ~code;
	assign expo   = inv[6:4];
	assign mant   = inv[3:0];
	assign biased = (MAG_W'({mant, 3'b000}) + ULAW_BIAS) << expo;
	assign mag    = biased - ULAW_BIAS;

endmodule

// ----- hw/rtl/ulaw_noise_gate_silence_trimmer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulaw_noise_gate_silence_trimmer_top
// Mu-law noise gate that trims long runs of quiet samples from a stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one mu-law byte per item in tdata. Each byte is expanded
//   to a linear magnitude; a magnitude below gate_threshold extends a run of
//   quiet samples, a louder one ends it. The byte leaves on m_axis unchanged
//   while the run is at or below max_silence, otherwise it is dropped.
//   Throughput is one item per clock while m_axis is ready: an input
//   register feeds the expander, run counter update and compare, which land
//   in the output register. The path has two register stages: an accepted
//   item enters the input register and, if kept, the output register once free.
//   When m_axis stalls, the output register holds its item and the input
//   register fills; s_axis_tready falls only when both are occupied.
//   Dropped items free their slot at once and cause no output.
//   Configuration: cfg_we with cfg_index 0 (gate_threshold, 15 bits) or
//   1 (max_silence, 16 bits) and cfg_wdata; write only while idle.
//   Reset (arst_n low) empties both stages, clears the quiet run and loads
//   gate_threshold = 300 and max_silence = 800.
// ----------------------------------------------------------------------------
module ulaw_noise_gate_silence_trimmer_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  logic [ungt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ungt_pkg::CFG_W-1:0]      cfg_wdata,
	// input stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // [7:0] ulaw_byte
	// output stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [7:0]                      m_axis_tdata   // [7:0] kept_byte
);
	import ungt_pkg::*;

	logic [THR_W-1:0]  gate_threshold_q;
	logic [SIL_W-1:0]  max_silence_q;
	logic [RUN_W-1:0]  quiet_run_q;

	logic              valid_s1;
	logic [CODE_W-1:0] code_s1;

	logic              out_valid_q;
	logic [CODE_W-1:0] out_data_q;

	logic              advance;
	logic [MAG_W-1:0]  mag;
	logic              quiet;
	logic [RUN_W-1:0]  run_next;
	logic              keep;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_threshold_q <= GATE_THRESHOLD_RST;
			max_silence_q    <= MAX_SILENCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GATE_THRESHOLD: gate_threshold_q <= cfg_wdata[THR_W-1:0];
				REG_MAX_SILENCE:    max_silence_q    <= cfg_wdata[SIL_W-1:0];
				default: ;
			endcase
		end
	end

	// Flow control: s1 moves on when the output slot is free or being taken
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			code_s1 <= s_axis_tdata;
		end
	end

	ungt_expand u_expand (
		.code (code_s1),
		.mag  (mag)
	);

	// Quiet run update, saturating one above the largest max_silence
	assign quiet    = mag < gate_threshold_q;
	assign run_next = !quiet ? '0 :
	                  (quiet_run_q == RUN_CAP) ? quiet_run_q : quiet_run_q + RUN_W'(1);
	assign keep     = run_next <= {1'b0, max_silence_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_run_q <= '0;
		end else if (valid_s1 && advance) begin
			quiet_run_q <= run_next;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_data_q <= code_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Assertions
	a_run_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		quiet_run_q <= RUN_CAP)
		else $error("quiet run counter passed its cap");

	a_loud_clears: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && !quiet |=> quiet_run_q == '0)
		else $error("loud sample did not clear quiet run");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(code_s1) && $stable(quiet_run_q))
		else $error("stalled input stage changed");

	a_drop_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && !keep |=> !out_valid_q)
		else $error("trimmed item reached the output");

endmodule
